@@ design/hed_pkg.sv @@
// ----------------------------------------------------------------------------
// hed_pkg: shared types and constants of the html entity decoder
// Phase codes, status codes, name store shape and name lookup tables.
// ----------------------------------------------------------------------------
package hed_pkg;

   localparam int MaxNameLenDefault = 8;
   localparam int CharW = 8;
   localparam int CpW = 21;
   localparam logic [CpW-1:0] CpMax = 21'h10FFFF;

   typedef enum logic [2:0] {
      PH_START = 3'd0,
      PH_NAME  = 3'd1,
      PH_HASH  = 3'd2,
      PH_HEX   = 3'd3,
      PH_DEC   = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNKNOWN   = 2'd1,
      ST_NODECODE  = 2'd2,
      ST_MALFORMED = 2'd3
   } status_type;

   localparam logic [CharW-1:0] ChHash = 8'h23;
   localparam logic [CharW-1:0] ChX    = 8'h78;

   // result of a table lookup
   typedef struct packed {
      logic           hit;
      logic [CpW-1:0] cp;
   } lookup_type;

   // decoded result handed to the output stage
   typedef struct packed {
      status_type     status;
      logic [CpW-1:0] cp;
   } result_type;

   // table keys hold up to eight bytes, first byte in the top bits
   typedef logic [63:0] key_type;

   function automatic key_type k(input string s);
      key_type r;
      r = '0;
      for (int i = 0; i < 8; i++) begin
         if (i < s.len()) r[63-8*i -: 8] = s[i];
      end
      return r;
   endfunction

   // control names, only when the normal table misses
   function automatic lookup_type ctrl_lookup(input key_type key);
      lookup_type r;
      r = '{hit: 1'b1, cp: '0};
      case (key)
         k("quot"): r.cp = 21'd34;
         k("amp"):  r.cp = 21'd38;
         k("lt"):   r.cp = 21'd60;
         k("gt"):   r.cp = 21'd62;
         default:   r.hit = 1'b0;
      endcase
      return r;
   endfunction

   // normal entity names
   function automatic lookup_type norm_lookup(input key_type key);
      lookup_type r;
      logic [13:0] v;
      v = '0;
      r.hit = 1'b1;
      case (key)
         k("circ"):v=710; k("tilde"):v=732; k("ensp"):v=8194; k("emsp"):v=8195;
         k("thinsp"):v=8201; k("zwnj"):v=8204; k("zwj"):v=8205; k("lrm"):v=8206;
         k("rlm"):v=8207; k("ndash"):v=8211; k("mdash"):v=8212;
         k("lsquo"):v=8216; k("rsquo"):v=8217; k("bdquo"):v=8222;
         k("dagger"):v=8224; k("Dagger"):v=8225; k("bull"):v=8226;
         k("hellip"):v=8230; k("permil"):v=8240; k("prime"):v=8242;
         k("Prime"):v=8243; k("lsaquo"):v=8249; k("rsaquo"):v=8250;
         k("oline"):v=8254; k("frasl"):v=8260; k("euro"):v=8364;
         k("nbsp"):v=160; k("iexcl"):v=161; k("cent"):v=162; k("pound"):v=163;
         k("curren"):v=164; k("yen"):v=165; k("brvbar"):v=166; k("sect"):v=167;
         k("uml"):v=168; k("copy"):v=169; k("ordf"):v=170; k("laquo"):v=171;
         k("not"):v=172; k("shy"):v=173; k("reg"):v=174; k("macr"):v=175;
         k("deg"):v=176; k("plusmn"):v=177; k("sup2"):v=178; k("sup3"):v=179;
         k("acute"):v=180; k("micro"):v=181; k("para"):v=182;
         k("middot"):v=183; k("cedil"):v=184; k("sup1"):v=185; k("ordm"):v=186;
         k("raquo"):v=187; k("frac14"):v=188; k("frac12"):v=189;
         k("frac34"):v=190; k("iquest"):v=191; k("Agrave"):v=192;
         k("Aacute"):v=193; k("Acirc"):v=194; k("Atilde"):v=195; k("Auml"):v=196;
         k("Aring"):v=197; k("AElig"):v=198; k("Ccedil"):v=199;
         k("Egrave"):v=200; k("Eacute"):v=201; k("Ecirc"):v=202; k("Euml"):v=203;
         k("Igrave"):v=204; k("Iacute"):v=205; k("Icirc"):v=206; k("Iuml"):v=207;
         k("ETH"):v=208; k("Ntilde"):v=209; k("Ograve"):v=210;
         k("Oacute"):v=211; k("Ocirc"):v=212; k("Otilde"):v=213; k("Ouml"):v=214;
         k("times"):v=215; k("Oslash"):v=216; k("Ugrave"):v=217;
         k("Uacute"):v=218; k("Ucirc"):v=219; k("Uuml"):v=220;
         k("Yacute"):v=221; k("THORN"):v=222; k("szlig"):v=223;
         k("agrave"):v=224; k("aacute"):v=225; k("acirc"):v=226;
         k("atilde"):v=227; k("auml"):v=228; k("aring"):v=229; k("aelig"):v=230;
         k("ccedil"):v=231; k("egrave"):v=232; k("eacute"):v=233;
         k("ecirc"):v=234; k("euml"):v=235; k("igrave"):v=236;
         k("iacute"):v=237; k("icirc"):v=238; k("iuml"):v=239; k("eth"):v=240;
         k("ntilde"):v=241; k("ograve"):v=242; k("oacute"):v=243;
         k("ocirc"):v=244; k("otilde"):v=245; k("ouml"):v=246;
         k("divide"):v=247; k("oslash"):v=248; k("ugrave"):v=249;
         k("uacute"):v=250; k("ucirc"):v=251; k("uuml"):v=252;
         k("yacute"):v=253; k("thorn"):v=254; k("yuml"):v=255;
         k("OElig"):v=338; k("oelig"):v=339; k("Scaron"):v=352;
         k("scaron"):v=353; k("Yuml"):v=376; k("fnof"):v=402;
         k("Alpha"):v=913; k("Beta"):v=914; k("Gamma"):v=915; k("Delta"):v=916;
         k("Epsilon"):v=917; k("Zeta"):v=918; k("Eta"):v=919; k("Theta"):v=920;
         k("Iota"):v=921; k("Kappa"):v=922; k("Lambda"):v=923; k("Mu"):v=924;
         k("Nu"):v=925; k("Xi"):v=926; k("Omicron"):v=927; k("Pi"):v=928;
         k("Rho"):v=929; k("Sigma"):v=931; k("Tau"):v=932; k("Upsilon"):v=933;
         k("Phi"):v=934; k("Chi"):v=935; k("Psi"):v=936; k("Omega"):v=937;
         k("alpha"):v=945; k("beta"):v=946; k("gamma"):v=947; k("delta"):v=948;
         k("epsilon"):v=949; k("zeta"):v=950; k("eta"):v=951; k("theta"):v=952;
         k("iota"):v=953; k("kappa"):v=954; k("lambda"):v=955; k("mu"):v=956;
         k("nu"):v=957; k("xi"):v=958; k("omicron"):v=959; k("pi"):v=960;
         k("rho"):v=961; k("sigmaf"):v=962; k("sigma"):v=963; k("tau"):v=964;
         k("upsilon"):v=965; k("phi"):v=966; k("chi"):v=967; k("psi"):v=968;
         k("omega"):v=969; k("thetasym"):v=977; k("upsih"):v=978;
         k("piv"):v=982; k("weierp"):v=8472; k("image"):v=8465;
         k("real"):v=8476; k("trade"):v=8482; k("alefsym"):v=8501;
         k("larr"):v=8592; k("uarr"):v=8593; k("rarr"):v=8594; k("darr"):v=8595;
         k("harr"):v=8596; k("crarr"):v=8629; k("lArr"):v=8656;
         k("uArr"):v=8657; k("rArr"):v=8658; k("dArr"):v=8659; k("hArr"):v=8660;
         k("forall"):v=8704; k("part"):v=8706; k("exist"):v=8707;
         k("empty"):v=8709; k("nabla"):v=8711; k("isin"):v=8712;
         k("notin"):v=8713; k("ni"):v=8715; k("prod"):v=8719; k("sum"):v=8721;
         k("minus"):v=8722; k("lowast"):v=8727; k("radic"):v=8730;
         k("prop"):v=8733; k("infin"):v=8734; k("ang"):v=8736; k("and"):v=8743;
         k("or"):v=8744; k("cap"):v=8745; k("cup"):v=8746; k("int"):v=8747;
         k("there4"):v=8756; k("sim"):v=8764; k("cong"):v=8773;
         k("asymp"):v=8776; k("ne"):v=8800; k("equiv"):v=8801; k("le"):v=8804;
         k("ge"):v=8805; k("sub"):v=8834; k("sup"):v=8835; k("nsub"):v=8836;
         k("sube"):v=8838; k("supe"):v=8839; k("oplus"):v=8853;
         k("otimes"):v=8855; k("perp"):v=8869; k("sdot"):v=8901;
         k("lceil"):v=8968; k("rceil"):v=8969; k("lfloor"):v=8970;
         k("rfloor"):v=8971; k("lang"):v=9001; k("rang"):v=9002;
         k("loz"):v=9674; k("spades"):v=9824; k("clubs"):v=9827;
         k("hearts"):v=9829; k("diams"):v=9830;
         default: r.hit = 1'b0;
      endcase
      r.cp = CpW'(v);
      return r;
   endfunction

endpackage

@@ design/html_entity_decoder_top.sv @@
// ----------------------------------------------------------------------------
// html_entity_decoder_top: html character entity decoder
// Decodes an entity body, one byte per beat, into status and code point.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one byte of the entity body per beat (text between
//   the ampersand and the semicolon); req_tlast marks its final byte.
//   rsp_ channel gives one beat per entity, on the body's final byte:
//   status in the low two bits of rsp_tdata, code point above it.
//   csr_we/csr_wdata write decode_control (1 decodes quot amp lt gt).
// Latency: the result beat is valid the cycle after the final byte.
// Throughput: one byte per cycle unless stalled; each byte's parse step and
//   the name table match are both done in the cycle that registers the result.
// Stall: one output register; a new byte is taken while it holds a beat
//   only if the same cycle drains it or the byte is not a final one.
// Reset: parser returns to start of entity, no result pending,
//   decode_control set to 1.
// ----------------------------------------------------------------------------
module html_entity_decoder_top #(
   parameter int MaxNameLen = hed_pkg::MaxNameLenDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_code
   input  logic        req_tlast,   // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [1:0] status, [22:2] code_point, [23] zero
   input  logic        csr_we,
   input  logic        csr_wdata
);
   import hed_pkg::*;

   localparam int LenW = $clog2(MaxNameLen+2);

   phase_type           phase_ff, phase_in;
   logic [20:0]         accum_ff, accum_in;
   logic                bad_ff, bad_in;
   logic [LenW-1:0]     len_ff, len_in;
   logic [MaxNameLen*8-1:0] name_ff, name_in;
   logic                ctl_ff;
   logic                vld_ff, vld_in;
   result_type          res_ff, res_in;

   logic        acc;
   logic        dbad;
   logic [20:0] dnext;
   result_type  name_res;

   assign req_tready = !vld_ff || rsp_tready || !req_tlast;
   assign acc        = req_tvalid && req_tready;

   hed_digit u_digit (
      .char_code  (req_tdata),
      .hex_mode   (phase_ff == PH_HEX),
      .accum      (accum_ff),
      .bad        (dbad),
      .accum_next (dnext)
   );

   hed_lookup #(.MaxNameLen(MaxNameLen)) u_lookup (
      .name_chars     (name_in),
      .name_len       (len_in),
      .decode_control (ctl_ff),
      .result         (name_res)
   );

   // parse step for one byte
   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      bad_in   = bad_ff;
      len_in   = len_ff;
      name_in  = name_ff;
      case (phase_ff)
         PH_START: begin
            if (req_tdata == ChHash) phase_in = PH_HASH;
            else begin
               phase_in = PH_NAME;
               name_in[7:0] = req_tdata;
               len_in = LenW'(1);
            end
         end
         PH_NAME: begin
            if (len_ff < LenW'(MaxNameLen)) begin
               name_in[8*len_ff[LenW-1:0] +: 8] = req_tdata;
               len_in = len_ff + LenW'(1);
            end else len_in = LenW'(MaxNameLen + 1);
         end
         PH_HASH: begin
            if (req_tdata == ChX) phase_in = PH_HEX;
            else begin
               phase_in = PH_DEC;
               if (dbad) bad_in = 1'b1;
               else accum_in = dnext;
            end
         end
         default: begin
            if (!bad_ff) begin
               if (dbad) bad_in = 1'b1;
               else accum_in = dnext;
            end
         end
      endcase
   end

   // result of the final byte
   always_comb begin
      if (phase_in == PH_NAME) res_in = name_res;
      else if (phase_in == PH_HASH || bad_in) res_in = '{status: ST_MALFORMED, cp: '0};
      else res_in = '{status: ST_OK, cp: accum_in};
   end

   assign vld_in = (acc && req_tlast) || (vld_ff && !rsp_tready);

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         accum_ff <= '0;
         bad_ff   <= 1'b0;
         len_ff   <= '0;
      end else if (acc) begin
         if (req_tlast) begin
            phase_ff <= PH_START;
            accum_ff <= '0;
            bad_ff   <= 1'b0;
            len_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            accum_ff <= accum_in;
            bad_ff   <= bad_in;
            len_ff   <= len_in;
         end
      end
   end

   // name bytes, no reset
   always_ff @(posedge clock) begin
      if (acc) name_ff <= name_in;
   end

   // control register and output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= 1'b1;
         vld_ff <= 1'b0;
      end else begin
         if (csr_we) ctl_ff <= csr_wdata;
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc && req_tlast) res_ff <= res_in;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {1'b0, res_ff.cp, res_ff.status};

   // checks
   property p_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty
   a_hold: assert property (p_hold) else $error("result changed while stalled");

   a_cp_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[22:2] <= CpMax)
      else $error("code point out of range");

   a_cp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1:0] != ST_OK |-> rsp_tdata[22:2] == '0)
      else $error("nonzero code point with error status");

   a_restart: assert property (@(posedge clock) disable iff (reset)
      acc && req_tlast |=> phase_ff == PH_START && len_ff == '0)
      else $error("parser not cleared after entity");

endmodule

@@ design/hed_lookup.sv @@
// ----------------------------------------------------------------------------
// hed_lookup: entity name match
// Compares the stored name against the normal and control name tables.
// ----------------------------------------------------------------------------
module hed_lookup #(
   parameter int MaxNameLen = hed_pkg::MaxNameLenDefault
) (
   input  logic [MaxNameLen*8-1:0] name_chars,
   input  logic [$clog2(MaxNameLen+2)-1:0] name_len,
   input  logic                    decode_control,
   output hed_pkg::result_type     result
);
   import hed_pkg::*;

   localparam int LenW = $clog2(MaxNameLen+2);

   key_type    key;
   logic       has_nul;
   lookup_type norm_hit;
   lookup_type ctrl_hit;

   // build key from the first eight bytes, name_chars[0] in the top byte
   // a zero byte inside the name would alias the key padding
   always_comb begin
      key     = '0;
      has_nul = 1'b0;
      for (int i = 0; i < 8; i++) begin
         if (LenW'(i) < name_len) begin
            key[63-8*i -: 8] = name_chars[8*i +: 8];
            if (name_chars[8*i +: 8] == 8'h00) has_nul = 1'b1;
         end
      end
   end

   assign norm_hit = norm_lookup(key);
   assign ctrl_hit = ctrl_lookup(key);

   // no table key is longer than eight bytes or holds a zero byte
   always_comb begin
      result = '{status: ST_UNKNOWN, cp: '0};
      if (name_len <= LenW'(8) && !has_nul) begin
         if (norm_hit.hit) begin
            result = '{status: ST_OK, cp: norm_hit.cp};
         end else if (ctrl_hit.hit) begin
            if (decode_control) result = '{status: ST_OK, cp: ctrl_hit.cp};
            else result = '{status: ST_NODECODE, cp: '0};
         end
      end
   end

endmodule

@@ design/hed_digit.sv @@
// ----------------------------------------------------------------------------
// hed_digit: numeric accumulator step
// Decodes one digit and folds it into the running value with range check.
// ----------------------------------------------------------------------------
module hed_digit (
   input  logic [7:0]  char_code,
   input  logic        hex_mode,
   input  logic [20:0] accum,
   output logic        bad,
   output logic [20:0] accum_next
);
   import hed_pkg::*;

   logic [3:0]  dval;
   logic        dok;
   logic [25:0] prod;

   // digit value
   always_comb begin
      dok  = 1'b1;
      dval = '0;
      if (char_code >= 8'h30 && char_code <= 8'h39) dval = 4'(char_code - 8'h30);
      else if (hex_mode && char_code >= 8'h61 && char_code <= 8'h66)
         dval = 4'(char_code - 8'h57);
      else if (hex_mode && char_code >= 8'h41 && char_code <= 8'h46)
         dval = 4'(char_code - 8'h37);
      else dok = 1'b0;
   end

   // value * base + digit, by shifts and adds
   always_comb begin
      if (hex_mode) prod = {accum, 4'b0} + 26'(dval);
      else prod = {2'b0, accum, 3'b0} + {4'b0, accum, 1'b0} + 26'(dval);
   end

   assign bad        = !dok || (prod > 26'(CpMax));
   assign accum_next = prod[20:0];

endmodule
